// ===== hw/rtl/bdq_pkg.sv =====
package bdq_pkg;

    localparam int DEPTH = 64;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int BYTE_W = 8;

    typedef enum logic [2:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_CLEAR      = 3'd4,
        OP_PEEK       = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        FAULT_NONE      = 2'd0,
        FAULT_OVERFLOW  = 2'd1,
        FAULT_UNDERFLOW = 2'd2
    } fault_t;

    typedef enum logic {
        ST_IDLE,
        ST_LOOKUP
    } state_t;

    typedef struct packed {
        logic [2:0]        func;
        logic [BYTE_W-1:0] letter;
    } req_t;

    typedef struct packed {
        logic [BYTE_W-1:0] front_letter;
        logic [BYTE_W-1:0] back_letter;
        logic [6:0]        entry_total;
        logic              is_empty;
        logic [1:0]        fault;
    } rsp_t;

    typedef struct packed {
        logic              wr_en;
        logic [IDX_W-1:0]  wr_addr;
        logic [BYTE_W-1:0] wr_data;
        logic [IDX_W-1:0]  rd_front;
        logic [IDX_W-1:0]  rd_back;
    } mem_cmd_t;

endpackage

// ===== hw/rtl/bdq_ram.sv =====
module bdq_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 8
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic [WIDTH-1:0]         rd_data_a,
    output logic [WIDTH-1:0]         rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_a_reg;
    logic [WIDTH-1:0] rd_data_b_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // forward a same-cycle write to either read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            if (wr_en && (wr_addr == rd_addr_a))
            begin
                rd_data_a_reg <= wr_data;
            end
            else
            begin
                rd_data_a_reg <= mem[rd_addr_a];
            end
            if (wr_en && (wr_addr == rd_addr_b))
            begin
                rd_data_b_reg <= wr_data;
            end
            else
            begin
                rd_data_b_reg <= mem[rd_addr_b];
            end
        end
    end

    assign rd_data_a = rd_data_a_reg;
    assign rd_data_b = rd_data_b_reg;

endmodule

// ===== hw/rtl/bdq_ptr.sv =====
module bdq_ptr
    import bdq_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             take,
    input  req_t             req,
    output mem_cmd_t         cmd,
    output logic [CNT_W-1:0] count,
    output fault_t           fault
);

    logic [IDX_W-1:0] front_reg;
    logic [IDX_W-1:0] front_next;
    logic [IDX_W-1:0] back_reg;
    logic [IDX_W-1:0] back_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    fault_t           fault_reg;
    fault_t           fault_next;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [IDX_W-1:0] front_inc;
    logic [IDX_W-1:0] front_dec;
    logic [IDX_W-1:0] back_inc;
    logic [IDX_W-1:0] back_dec;

    assign front_inc = (front_reg == IDX_W'(DEPTH - 1)) ? '0 : front_reg + 1'b1;
    assign front_dec = (front_reg == '0) ? IDX_W'(DEPTH - 1) : front_reg - 1'b1;
    assign back_inc  = (back_reg == IDX_W'(DEPTH - 1)) ? '0 : back_reg + 1'b1;
    assign back_dec  = (back_reg == '0) ? IDX_W'(DEPTH - 1) : back_reg - 1'b1;

    always_comb
    begin
        front_next = front_reg;
        back_next  = back_reg;
        count_next = count_reg;
        fault_next = FAULT_NONE;
        wr_en      = 1'b0;
        wr_addr    = front_reg;
        case (req.func) inside
            OP_PUSH_FRONT, OP_PUSH_BACK:
            begin
                if (count_reg == CNT_W'(DEPTH))
                begin
                    fault_next = FAULT_OVERFLOW;
                end
                else
                begin
                    wr_en      = 1'b1;
                    count_next = count_reg + 1'b1;
                    if (count_reg == '0)
                    begin
                        back_next = front_reg;
                        wr_addr   = front_reg;
                    end
                    else if (req.func == OP_PUSH_FRONT)
                    begin
                        front_next = front_dec;
                        wr_addr    = front_dec;
                    end
                    else
                    begin
                        back_next = back_inc;
                        wr_addr   = back_inc;
                    end
                end
            end
            OP_POP_FRONT, OP_POP_BACK:
            begin
                if (count_reg == '0)
                begin
                    fault_next = FAULT_UNDERFLOW;
                end
                else
                begin
                    count_next = count_reg - 1'b1;
                    if (count_reg == CNT_W'(1))
                    begin
                        back_next = front_reg;
                    end
                    else if (req.func == OP_POP_FRONT)
                    begin
                        front_next = front_inc;
                    end
                    else
                    begin
                        back_next = back_dec;
                    end
                end
            end
            OP_CLEAR:
            begin
                front_next = '0;
                back_next  = '0;
                count_next = '0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= '0;
            back_reg  <= '0;
            count_reg <= '0;
            fault_reg <= FAULT_NONE;
        end
        else if (take)
        begin
            front_reg <= front_next;
            back_reg  <= back_next;
            count_reg <= count_next;
            fault_reg <= fault_next;
        end
    end

    assign cmd.wr_en    = take && wr_en;
    assign cmd.wr_addr  = wr_addr;
    assign cmd.wr_data  = req.letter;
    assign cmd.rd_front = front_next;
    assign cmd.rd_back  = back_next;
    assign count        = count_reg;
    assign fault        = fault_reg;

endmodule

// ===== hw/rtl/byte_deque_buffer_unit.sv =====
// Timing: accepting a request beat moves the block from idle to the lookup state, which
// loads its response beat into the output register when that is empty or being taken.
// No new request is taken until then; the pointer update shares its cycle with the end-slot
// reads of the single-write, dual-read byte memory, whose data lands in its read registers.
// Reset: asynchronous, active low; clears pointers, count and handshake state.
// Memory contents are not cleared; no clearing pass is needed.
module byte_deque_buffer_unit
    import bdq_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    state_t            state_reg;
    state_t            state_next;
    logic              take;
    logic              load;
    mem_cmd_t          cmd;
    logic [CNT_W-1:0]  count;
    fault_t            fault;
    logic [BYTE_W-1:0] front_data;
    logic [BYTE_W-1:0] back_data;
    rsp_t              rsp_reg;
    rsp_t              rsp_next;
    logic              rsp_valid_reg;
    logic              rsp_valid_next;

    bdq_ptr u_ptr (
        .clk   (clk),
        .rst_n (rst_n),
        .take  (take),
        .req   (req),
        .cmd   (cmd),
        .count (count),
        .fault (fault)
    );

    bdq_ram #(
        .DEPTH (DEPTH),
        .WIDTH (BYTE_W)
    ) u_ram (
        .clk       (clk),
        .wr_en     (cmd.wr_en),
        .wr_addr   (cmd.wr_addr),
        .wr_data   (cmd.wr_data),
        .rd_en     (take),
        .rd_addr_a (cmd.rd_front),
        .rd_addr_b (cmd.rd_back),
        .rd_data_a (front_data),
        .rd_data_b (back_data)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req_stall = 1'b1;
        load      = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                req_stall = 1'b0;
            end
            ST_LOOKUP:
            begin
                load = !rsp_valid_reg || !rsp_stall;
            end
            default:
            begin
            end
        endcase
    end

    assign take = req_valid && !req_stall;

    always_comb
    begin
        rsp_next.entry_total  = 7'(count);
        rsp_next.is_empty     = (count == '0);
        rsp_next.fault        = fault;
        rsp_next.front_letter = (count == '0) ? '0 : front_data;
        rsp_next.back_letter  = (count == '0) ? '0 : back_data;
    end

    assign rsp_valid_next = load || (rsp_valid_reg && rsp_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // hold the beat while stalled
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule
